@@ sv/tlcm_pkg.sv @@
// Shared types and constants for the tone table and color matrix pixel unit.
// No dependencies; imported by every module of the block.
package tlcm_pkg;

    localparam int CHAN_W     = 8;
    localparam int TABLE_AW   = 8;
    localparam int CFG_DATA_W = 48;
    localparam int SLOT_W     = 16;
    localparam int NUM_CHAN   = 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    typedef enum logic [1:0] {
        CFG_RED_ROW   = 2'd0,
        CFG_GREEN_ROW = 2'd1,
        CFG_BLUE_ROW  = 2'd2,
        CFG_BYPASS    = 2'd3
    } cfg_index_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        logic  mode;
        chan_t red_in;
        chan_t green_in;
        chan_t blue_in;
        chan_t alpha_in;
        chan_t table_index;
        chan_t table_value;
    } pixel_in_t;

    typedef struct packed {
        chan_t red_out;
        chan_t green_out;
        chan_t blue_out;
        chan_t alpha_out;
    } pixel_out_t;

endpackage

@@ sv/tlcm_tone_table.sv @@
// Tone table: two copies of the 256-entry table, one read at the red and green
// addresses, the other at the blue address. Both take the same write. Uses tlcm_pkg.
module tlcm_tone_table
    import tlcm_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [TABLE_AW-1:0] wr_addr,
    input  chan_t               wr_data,
    input  logic                rd_en,
    input  rgb_t                rd_addr,
    output rgb_t                rd_data
);

    localparam int DEPTH = 1 << TABLE_AW;

    chan_t mem_rg [DEPTH];
    chan_t mem_b  [DEPTH];
    rgb_t  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_rg[wr_addr] <= wr_data;
            mem_b[wr_addr]  <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg[0] <= mem_rg[rd_addr[0]];
            rd_data_reg[1] <= mem_rg[rd_addr[1]];
            rd_data_reg[2] <= mem_b[rd_addr[2]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/tone_lut_color_matrix_pixel_unit.sv @@
// Top level of the tone table and 3x3 color matrix pixel unit.
// Depends on tlcm_pkg and tlcm_tone_table.
//
//  channel  | signals                              | transaction
//  ---------+--------------------------------------+-----------------------------------
//  in       | in_valid, in_ready, in_data          | one pixel or one table load
//  out      | out_valid, out_ready, out_data       | one adjusted pixel (pixels only)
//  cfg      | cfg_write, cfg_index, cfg_data       | one register write, no wait
//
// One transaction per cycle in steady state while the output is taken; an accepted
// pixel passes through table read, products, and row sums into the output register.
// A load writes all table copies at acceptance and leaves a bubble behind it.
// Reset clears the pipeline valids and the weights and sets bypass; the table is not cleared.
// When the output register is full and not taken, the whole pipeline holds and
// in_ready drops.
module tone_lut_color_matrix_pixel_unit
    import tlcm_pkg::*;
#(
    parameter int FRACTION_BITS = 12,
    parameter int WEIGHT_WIDTH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pixel_in_t             in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pixel_out_t            out_data,
    input  logic                  cfg_write,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // product of a 9-bit signed channel and a weight, and a sum of three of them
    localparam int PROD_W = WEIGHT_WIDTH + CHAN_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // weights: [output row][input channel]
    logic [NUM_CHAN-1:0][NUM_CHAN-1:0][WEIGHT_WIDTH-1:0] weight_reg;
    logic                                                bypass_reg;

    logic advance;
    logic accept;

    logic  s1_valid_reg;
    chan_t s1_alpha_reg;
    rgb_t  tone_rgb;

    logic                                  s2_valid_reg;
    chan_t                                 s2_alpha_reg;
    rgb_t                                  s2_rgb_reg;
    logic signed [PROD_W-1:0]              prod_next [NUM_CHAN][NUM_CHAN];
    logic signed [PROD_W-1:0]              prod_reg  [NUM_CHAN][NUM_CHAN];

    logic signed [SUM_W-1:0] row_sum     [NUM_CHAN];
    logic signed [SUM_W-1:0] row_shifted [NUM_CHAN];
    rgb_t                    matrix_rgb;

    logic       out_valid_reg;
    pixel_out_t out_reg;
    pixel_out_t out_next;

    // whole pipeline moves together whenever the output register can take data
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            bypass_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RED_ROW, CFG_GREEN_ROW, CFG_BLUE_ROW:
                begin
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        weight_reg[cfg_index][c] <= cfg_data[SLOT_W*c +: WEIGHT_WIDTH];
                    end
                end
                CFG_BYPASS:
                begin
                    bypass_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // table read at acceptance, data registered inside the table
    tlcm_tone_table u_table (
        .clk     (clk),
        .wr_en   (accept && (in_data.mode == MODE_LOAD)),
        .wr_addr (in_data.table_index),
        .wr_data (in_data.table_value),
        .rd_en   (advance),
        .rd_addr ({in_data.blue_in, in_data.green_in, in_data.red_in}),
        .rd_data (tone_rgb)
    );

    // stage 1: drop loads, keep pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid && (in_data.mode == MODE_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_alpha_reg <= in_data.alpha_in;
        end
    end

    // stage 2: nine products of table value and weight
    always_comb
    begin
        for (int r = 0; r < NUM_CHAN; r++)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                prod_next[r][c] = $signed({1'b0, tone_rgb[c]})
                                  * $signed(weight_reg[r][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_alpha_reg <= s1_alpha_reg;
            s2_rgb_reg   <= tone_rgb;
            prod_reg     <= prod_next;
        end
    end

    // stage 3: row sums, clamp at zero, drop the fraction, saturate
    always_comb
    begin
        for (int r = 0; r < NUM_CHAN; r++)
        begin
            row_sum[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                         + SUM_W'(prod_reg[r][2]);
            row_shifted[r] = row_sum[r] >>> FRACTION_BITS;
            if (row_sum[r][SUM_W-1] || (row_sum[r] == '0))
            begin
                matrix_rgb[r] = '0;
            end
            else if (row_shifted[r] > $signed(SUM_W'(CHAN_MAX)))
            begin
                matrix_rgb[r] = CHAN_MAX;
            end
            else
            begin
                matrix_rgb[r] = row_shifted[r][CHAN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (bypass_reg)
        begin
            out_next.red_out   = s2_rgb_reg[0];
            out_next.green_out = s2_rgb_reg[1];
            out_next.blue_out  = s2_rgb_reg[2];
        end
        else
        begin
            out_next.red_out   = matrix_rgb[0];
            out_next.green_out = matrix_rgb[1];
            out_next.blue_out  = matrix_rgb[2];
        end
        out_next.alpha_out = s2_alpha_reg;
    end

    // output register: hold while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
